[src/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
package spq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;

   localparam int TAG_W  = 16;
   localparam int PRIO_W = 3;
   localparam int OCC_W  = 6;

   // Priorities run 1..PRIO_LIMIT-1; 1 is most urgent.
   localparam logic [PRIO_W-1:0] PRIO_NONE  = 3'd0;
   localparam logic [PRIO_W-1:0] PRIO_LIMIT = 3'd6;

   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

endpackage

[src/stable_priority_queue_unit.sv]
// Stable priority queue: tagged entries in arrival order, most-urgent-first dequeue.
//
// A command word is taken when start is high and busy is low; func 0 appends
// (item_tag, item_priority) at the tail, func 1 removes the entry with the
// numerically lowest priority, oldest first among equals. Every command gives
// exactly one result word, shown for a single cycle with rsp_valid high; there
// is no back-pressure, so the receiver must take it in that cycle. Timing: an
// enqueue, or a dequeue on an empty queue, answers on the cycle after the
// command. A dequeue first scans the slots through the single registered
// read port of the entry store with one priority comparator, then moves each
// entry after the winner, if any, down a slot, read and write overlapped, and
// answers once the last one is moved. busy stays high for all of that; a new
// command may be given in the very cycle the result word is shown. Refused
// enqueues (queue full, or priority 0, 6 or 7) leave the queue untouched and
// return ok low. No clearing pass is needed after reset: only slots below
// the fill count are ever read.
module stable_priority_queue_unit #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [spq_pkg::TAG_W-1:0]  req_item_tag,
   input  logic [spq_pkg::PRIO_W-1:0] req_item_priority,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic [spq_pkg::TAG_W-1:0]  rsp_out_tag,
   output logic [spq_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]  rsp_occupancy
);
   import spq_pkg::*;

   // slot index width and fill count width (count must reach QUEUE_DEPTH)
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // entry store: one write port, one registered read port
   logic [TAG_W-1:0]  slot_tag_ff  [QUEUE_DEPTH];
   logic [PRIO_W-1:0] slot_prio_ff [QUEUE_DEPTH];
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [PRIO_W-1:0] rd_prio_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [TAG_W-1:0]  wr_tag;
   logic [PRIO_W-1:0] wr_prio;

   // sequencer state
   state_type         state_ff,     state_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic [CNT_W-1:0]  cmp_ff,       cmp_in;       // slot whose data is on the read port
   logic [CNT_W-1:0]  best_ff,      best_in;      // best slot; write pointer while shifting
   logic [TAG_W-1:0]  best_tag_ff,  best_tag_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;

   // result word
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff,    rsp_ok_in;
   logic [TAG_W-1:0]  rsp_tag_ff,   rsp_tag_in;
   logic [PRIO_W-1:0] rsp_prio_ff,  rsp_prio_in;
   logic [OCC_W-1:0]  rsp_occ_ff,   rsp_occ_in;

   // shared compare unit and helpers
   logic              take_new;
   logic [CNT_W-1:0]  best_sel;
   logic [TAG_W-1:0]  sel_tag;
   logic [PRIO_W-1:0] sel_prio;
   logic [CNT_W-1:0]  cmp_next;
   logic [CNT_W-1:0]  best_next;
   logic [CNT_W-1:0]  best_skip;
   logic [CNT_W-1:0]  count_dec;
   logic              prio_legal;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_tag_ff[wr_addr]  <= wr_tag;
         slot_prio_ff[wr_addr] <= wr_prio;
      end
      rd_tag_ff  <= slot_tag_ff[rd_addr];
      rd_prio_ff <= slot_prio_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ff       <= cmp_in;
      best_ff      <= best_in;
      best_tag_ff  <= best_tag_in;
      best_prio_ff <= best_prio_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   always_comb begin
      // strict less-than keeps the oldest of equal priorities
      take_new   = (cmp_ff == '0) || (rd_prio_ff < best_prio_ff);
      best_sel   = take_new ? cmp_ff     : best_ff;
      sel_tag    = take_new ? rd_tag_ff  : best_tag_ff;
      sel_prio   = take_new ? rd_prio_ff : best_prio_ff;
      cmp_next   = CNT_W'(cmp_ff + 1'b1);
      best_next  = CNT_W'(best_sel + 1'b1);
      best_skip  = CNT_W'(best_ff + 2'd2);
      count_dec  = CNT_W'(count_ff - 1'b1);
      prio_legal = (req_item_priority != PRIO_NONE) && (req_item_priority < PRIO_LIMIT);

      state_in     = state_ff;
      count_in     = count_ff;
      cmp_in       = cmp_ff;
      best_in      = best_ff;
      best_tag_in  = best_tag_ff;
      best_prio_in = best_prio_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_occ_in   = rsp_occ_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_tag       = req_item_tag;
      wr_prio      = req_item_priority;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_ENQ) begin
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = '0;
                  rsp_prio_in  = PRIO_NONE;
                  if ((count_ff < CNT_W'(QUEUE_DEPTH)) && prio_legal) begin
                     wr_en      = 1'b1;
                     count_in   = CNT_W'(count_ff + 1'b1);
                     rsp_ok_in  = 1'b1;
                     rsp_occ_in = OCC_W'(CNT_W'(count_ff + 1'b1));
                  end else begin
                     rsp_ok_in  = 1'b0;
                     rsp_occ_in = OCC_W'(count_ff);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_tag_in   = '0;
                  rsp_prio_in  = PRIO_NONE;
                  rsp_occ_in   = OCC_W'(count_ff);
               end else begin
                  rd_addr  = '0;
                  cmp_in   = '0;
                  best_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            best_in      = best_sel;
            best_tag_in  = sel_tag;
            best_prio_in = sel_prio;
            if (cmp_next < count_ff) begin
               rd_addr = cmp_next[IDX_W-1:0];
               cmp_in  = cmp_next;
            end else if (best_next < count_ff) begin
               rd_addr  = best_next[IDX_W-1:0];
               state_in = ST_SHIFT;
            end else begin
               // winner is the tail slot: nothing to move
               count_in     = count_dec;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_tag_in   = sel_tag;
               rsp_prio_in  = sel_prio;
               rsp_occ_in   = OCC_W'(count_dec);
               state_in     = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            // slot best+1 is on the read port; drop it into slot best
            wr_en   = 1'b1;
            wr_addr = best_ff[IDX_W-1:0];
            wr_tag  = rd_tag_ff;
            wr_prio = rd_prio_ff;
            if (best_skip < count_ff) begin
               rd_addr = best_skip[IDX_W-1:0];
               best_in = CNT_W'(best_ff + 1'b1);
            end else begin
               count_in     = count_dec;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_tag_in   = best_tag_ff;
               rsp_prio_in  = best_prio_ff;
               rsp_occ_in   = OCC_W'(count_dec);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // a result word is only shown once the sequencer is back to idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while sequencer busy");

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count beyond depth");

   // an accepted command either answers next cycle or starts a dequeue
   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted command lost");

   // any returned priority other than PRIO_NONE is a legal one and comes with ok high
   a_prio_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_priority != PRIO_NONE)
         |-> (rsp_ok && rsp_out_priority < PRIO_LIMIT))
      else $error("illegal priority returned");

   // shifting only follows a scan
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_SHIFT) |-> ($past(state_ff) == ST_SCAN))
      else $error("shift without scan");

endmodule

[test/tb.sv]
// Self-checking testbench for the stable priority queue unit.
module tb;
   import spq_pkg::*;

   // Sizes of the run. The slowest word is a dequeue on a full queue whose
   // winner sits in slot 0, since every later entry must move down. Add the longest
   // sender gap and the stall limit still leaves a wide margin.
   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int RANDOM_WORDS = 1450;
   localparam int MIX_WINDOW   = 64;
   localparam int QUIET_TAIL   = 150;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

   typedef struct {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct {
      logic              ok;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [OCC_W-1:0]  occ;
   } result_type;

   // Bias of the random words: fill pushes the queue up to full, drain empties it.
   typedef enum { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_type;

   // Keeps its own copy of the queue in arrival order and the result words
   // that the accepted commands are owed, oldest first.
   class spq_scoreboard;
      entry_type   held[$];
      result_type  awaited[$];
      int unsigned failures;
      int unsigned enq_taken, enq_refused, full_refused;
      int unsigned deq_served, deq_empty, peak;

      function void note_command(logic func, logic [TAG_W-1:0] tag,
                                 logic [PRIO_W-1:0] prio);
         result_type r;
         entry_type  e;
         int         best;
         r.ok   = 1'b0;
         r.tag  = '0;
         r.prio = PRIO_NONE;
         if (func == FUNC_ENQ) begin
            if (held.size() >= DEPTH || prio == PRIO_NONE || prio >= PRIO_LIMIT) begin
               // refused: queue untouched
               enq_refused++;
               if (held.size() >= DEPTH) full_refused++;
            end else begin
               e.tag  = tag;
               e.prio = prio;
               held.insert(held.size(), e);
               r.ok = 1'b1;
               enq_taken++;
               if (held.size() > peak) peak = held.size();
            end
         end else if (held.size() == 0) begin
            deq_empty++;
         end else begin
            // strict less-than keeps the oldest among equal priorities
            best = 0;
            foreach (held[i])
               if (held[i].prio < held[best].prio) best = i;
            r.ok   = 1'b1;
            r.tag  = held[best].tag;
            r.prio = held[best].prio;
            held.delete(best);
            deq_served++;
         end
         r.occ = OCC_W'(held.size());
         awaited.insert(awaited.size(), r);
      endfunction

      function void check_word(logic ok, logic [TAG_W-1:0] tag,
                               logic [PRIO_W-1:0] prio, logic [OCC_W-1:0] occ);
         result_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result word: ok %b tag %h priority %0d occupancy %0d",
                   ok, tag, prio, occ);
            failures++;
         end else begin
            want = awaited.pop_front();
            if (ok !== want.ok) begin
               $error("ok: expected %b, actual %b", want.ok, ok);
               failures++;
            end
            if (tag !== want.tag) begin
               $error("out_tag: expected %h, actual %h", want.tag, tag);
               failures++;
            end
            if (prio !== want.prio) begin
               $error("out_priority: expected %0d, actual %0d", want.prio, prio);
               failures++;
            end
            if (occ !== want.occ) begin
               $error("occupancy: expected %0d, actual %0d", want.occ, occ);
               failures++;
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_func;
   logic [TAG_W-1:0]  req_item_tag;
   logic [PRIO_W-1:0] req_item_priority;
   logic              rsp_valid;
   logic              rsp_ok;
   logic [TAG_W-1:0]  rsp_out_tag;
   logic [PRIO_W-1:0] rsp_out_priority;
   logic [OCC_W-1:0]  rsp_occupancy;

   spq_scoreboard board;
   int unsigned   stall_cycles;

   stable_priority_queue_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_item_tag      (req_item_tag),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

   always #6 clock = ~clock;

   // Result words last one cycle and cannot be held off, so every strobe is
   // taken at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_word(rsp_ok, rsp_out_tag, rsp_out_priority, rsp_occupancy);
   end

   // Watchdog: a cycle counts as a stall if no command and no result word
   // changes hands at its closing edge.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Presents one command word and returns at the edge that takes it. start
   // is left high so that a following word goes out back to back; whoever
   // comes next lowers it if a gap is wanted.
   task automatic send_word(input logic func, input logic [TAG_W-1:0] tag,
                            input logic [PRIO_W-1:0] prio);
      start             <= 1'b1;
      req_func          <= func;
      req_item_tag      <= tag;
      req_item_priority <= prio;
      do @(posedge clock); while (busy);
      board.note_command(func, tag, prio);
   endtask

   // Sender gap; the payload ports carry junk meanwhile.
   task automatic pause_sender(input int cycles);
      start             <= 1'b0;
      req_func          <= 1'($urandom_range(1));
      req_item_tag      <= TAG_W'($urandom_range(16'hFFFF));
      req_item_priority <= PRIO_W'($urandom_range(7));
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pick_word(input mix_type mix, output logic func,
                            output logic [TAG_W-1:0] tag, output logic [PRIO_W-1:0] prio);
      int roll;
      roll = $urandom_range(3);
      case (mix)
         MIX_FILL:  func = (roll == 0) ? FUNC_DEQ : FUNC_ENQ;
         MIX_DRAIN: func = (roll == 0) ? FUNC_ENQ : FUNC_DEQ;
         default:   func = roll[0] ? FUNC_DEQ : FUNC_ENQ;
      endcase
      tag = TAG_W'($urandom_range(16'hFFFF));
      // mostly legal priorities, now and then one the queue must refuse
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0:       prio = PRIO_NONE;
            1:       prio = PRIO_LIMIT;
            default: prio = 3'd7;
         endcase
      end else begin
         prio = PRIO_W'($urandom_range(5, 1));
      end
   endtask

   initial begin
      logic              func;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      mix_type           mix;
      bit                gaps_on;
      board = new();
      reset             <= 1'b1;
      start             <= 1'b0;
      req_func          <= FUNC_ENQ;
      req_item_tag      <= '0;
      req_item_priority <= PRIO_NONE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: dequeue on an empty queue (payload ignored), refused
      // priorities 0, 6 and 7, tag extremes, ties on priorities 3 and 1.
      send_word(FUNC_DEQ, 16'hBEEF, 3'd2);
      send_word(FUNC_ENQ, 16'h1111, PRIO_NONE);
      send_word(FUNC_ENQ, 16'h2222, PRIO_LIMIT);
      send_word(FUNC_ENQ, 16'h3333, 3'd7);
      send_word(FUNC_ENQ, 16'h0000, 3'd5);
      send_word(FUNC_ENQ, 16'hFFFF, 3'd1);
      send_word(FUNC_ENQ, 16'h1234, 3'd3);
      send_word(FUNC_ENQ, 16'h5678, 3'd3);
      send_word(FUNC_ENQ, 16'hAAAA, 3'd1);
      send_word(FUNC_ENQ, 16'h5555, 3'd2);
      pause_sender(3);
      // expect FFFF, AAAA, 5555, 1234, 5678, 0000, then empty
      repeat (7) send_word(FUNC_DEQ, TAG_W'($urandom_range(16'hFFFF)),
                           PRIO_W'($urandom_range(7)));

      // Random part: windows biased towards filling, draining or neither,
      // so the queue swings between empty and full. Sender gaps come in
      // bursts in some windows and none at all over the final stretch.
      mix     = MIX_FILL;
      gaps_on = 1'b0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % MIX_WINDOW == 0) begin
            mix     = mix_type'($urandom_range(2));
            gaps_on = (n < RANDOM_WORDS - QUIET_TAIL) && ($urandom_range(3) != 0);
         end
         if (gaps_on && $urandom_range(3) == 0)
            pause_sender($urandom_range(19, 1));
         pick_word(mix, func, tag, prio);
         send_word(func, tag, prio);
      end
      start <= 1'b0;

      // Drain what is owed, then watch a while for stray result words.
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered: %0d enqueues taken, %0d refused (%0d on a full queue)",
               board.enq_taken, board.enq_refused, board.full_refused);
      $display("covered: %0d dequeues served, %0d on an empty queue, peak fill %0d",
               board.deq_served, board.deq_empty, board.peak);
      if (board.failures == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
